// File: sv/ica_pkg.sv
`timescale 1ns / 1ps
package ica_pkg;
    localparam int AXES = 6;
    localparam int MAX_STEPS = 24;
    // samples per running window; the gyro step divides by a shift, so keep a power of two
    localparam int WINDOW_LENGTH = 4;
    localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
    localparam logic [15:0] BLEND_RESET = 16'd62915;
    localparam logic [23:0] GAIN_RESET = 24'd163930;
    localparam logic CFG_BLEND = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SUMRD, S_SUMWR, S_SQRT, S_CORD_P, S_CORD_R,
        S_GYRO, S_BLEND, S_OUT
    } t_state;

    function automatic logic [22:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 23'd2949120;
            5'd1: atan_q16 = 23'd1740967;
            5'd2: atan_q16 = 23'd919879;
            5'd3: atan_q16 = 23'd466945;
            5'd4: atan_q16 = 23'd234379;
            5'd5: atan_q16 = 23'd117266;
            5'd6: atan_q16 = 23'd58666;
            5'd7: atan_q16 = 23'd29335;
            5'd8: atan_q16 = 23'd14668;
            5'd9: atan_q16 = 23'd7334;
            5'd10: atan_q16 = 23'd3667;
            5'd11: atan_q16 = 23'd1833;
            5'd12: atan_q16 = 23'd917;
            5'd13: atan_q16 = 23'd458;
            5'd14: atan_q16 = 23'd229;
            5'd15: atan_q16 = 23'd115;
            5'd16: atan_q16 = 23'd57;
            5'd17: atan_q16 = 23'd29;
            5'd18: atan_q16 = 23'd14;
            5'd19: atan_q16 = 23'd7;
            5'd20: atan_q16 = 23'd4;
            5'd21: atan_q16 = 23'd2;
            5'd22: atan_q16 = 23'd1;
            default: atan_q16 = 23'd0;
        endcase
    endfunction
endpackage

// File: sv/ica_if.sv
`timescale 1ns / 1ps
interface ica_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic read_failed;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    read_failed, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  read_failed, output ready);
endinterface

interface ica_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] pitch_q16;
    logic signed [31:0] roll_q16;
    logic signed [24:0] yaw_deg;
    logic angles_ok;
    modport source (output valid, pitch_q16, roll_q16, yaw_deg, angles_ok, input ready);
    modport sink (input valid, pitch_q16, roll_q16, yaw_deg, angles_ok, output ready);
endinterface

interface ica_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/ica_ram.sv
`timescale 1ns / 1ps
module ica_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/ica_cordic.sv
`timescale 1ns / 1ps
module ica_cordic #(
    parameter int STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [21:0]  i_y,
    input  logic signed [21:0]  i_x,
    output logic                o_done,
    output logic signed [25:0]  o_angle
);
    import ica_pkg::*;
    localparam int NSTEP = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
    logic signed [44:0] r_x, r_y;
    logic signed [27:0] r_z;
    logic [4:0] r_i;
    logic r_busy;
    logic signed [44:0] xs, ys;
    logic signed [21:0] ax, ay;
    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        ax = (i_x < 0) ? -i_x : i_x;
        ay = (i_x < 0) ? -i_y : i_y;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                r_x <= 45'(ax) <<< 20;
                r_y <= 45'(ay) <<< 20;
                if (i_x == 0 && i_y == 0) begin
                    r_z <= '0;
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_z <= (i_x < 0) ? ((i_y >= 0) ? 28'(HALF_TURN) : -28'(HALF_TURN)) : '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + 28'(atan_q16(r_i));
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - 28'(atan_q16(r_i));
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_angle = 26'(r_z);
endmodule

// File: sv/imu_complementary_attitude.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in      | in  | accel_x/y/z, rate_x/y/z, read_failed
// out     | out | pitch_q16, roll_q16, yaw_deg, angles_ok
// cfg     | in  | index (0 blend_weight, 1 gyro_step_gain), data
// One item at a time: a good sample passes through six sum read-modify-writes (S_SUMRD,
// S_SUMWR), 22 square root steps (S_SQRT), two CORDIC runs (pitch, then roll; a zero
// vector finishes at once), the gyro and blend phases and S_OUT into the output register.
// A failed read goes straight to S_OUT; the next item is taken only in S_IDLE.
// Reset is synchronous; a clear pass then zeroes history and sums before any item is taken.
// A waiting result holds the next item in its last state until the output register frees.
module imu_complementary_attitude #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ica_in_if.sink   in_ch,
    ica_out_if.source out_ch,
    ica_cfg_if.sink  cfg_ch
);
    import ica_pkg::*;
    localparam int HDEPTH = AXES * WINDOW_LENGTH;
    localparam int HAW = $clog2(HDEPTH);
    localparam int SLW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int SUMW = 16 + $clog2(WINDOW_LENGTH) + 1;

    t_state r_state, n_state;
    logic [15:0] r_blend;
    logic [23:0] r_gain;
    logic [SLW-1:0] r_slot;
    logic r_clr;
    logic [HAW-1:0] r_clr_addr;
    logic [2:0] r_axis;
    logic [1:0] r_ph;
    logic signed [15:0] r_smp [AXES];
    logic signed [SUMW-1:0] r_sum [AXES];
    logic r_fail;
    logic signed [31:0] r_pitch, r_roll, r_head;
    logic signed [31:0] r_opitch, r_oroll;
    logic signed [24:0] r_oyaw;
    logic r_ook, r_ovalid;
    logic out_free;

    // history memory and sum memory
    logic h_we, s_we;
    logic [HAW-1:0] h_addr;
    logic [15:0] h_wdata, h_rdata;
    logic [2:0] s_addr;
    logic [SUMW-1:0] s_wdata, s_rdata;
    logic [HAW-1:0] h_idx;
    logic signed [SUMW-1:0] new_sum;

    assign h_idx = HAW'(r_axis * WINDOW_LENGTH) + HAW'(r_slot);
    assign h_addr = r_clr ? r_clr_addr : h_idx;
    // the clear pass covers the sum memory in its first AXES addresses
    assign s_addr = r_clr ? 3'(r_clr_addr) : r_axis;
    assign new_sum = $signed(s_rdata) - SUMW'($signed(h_rdata)) + SUMW'(r_smp[r_axis]);
    assign h_wdata = r_clr ? '0 : r_smp[r_axis];
    assign s_wdata = r_clr ? '0 : new_sum;
    assign h_we = r_clr || (r_state == S_SUMWR);
    assign s_we = r_clr ? (r_clr_addr < HAW'(AXES)) : (r_state == S_SUMWR);

    ica_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_addr), .i_wdata(h_wdata),
        .i_raddr(h_addr), .o_rdata(h_rdata));
    ica_ram #(.WIDTH(SUMW), .DEPTH(AXES)) u_sums (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_addr), .i_wdata(s_wdata),
        .i_raddr(s_addr), .o_rdata(s_rdata));

    // integer square root, one result bit per cycle
    logic [43:0] r_sq_n;
    logic [43:0] r_sq_res, r_sq_bit;
    logic [43:0] sq_t;
    assign sq_t = r_sq_res + r_sq_bit;

    // CORDIC: the pitch run starts on leaving S_SQRT, the roll run on leaving S_CORD_P
    logic c_start, c_done;
    logic signed [21:0] c_y, c_x;
    logic signed [25:0] c_angle;
    logic signed [25:0] r_acc_p, r_acc_r;
    ica_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_y(c_y), .i_x(c_x),
        .o_done(c_done), .o_angle(c_angle));
    assign c_y = (r_state == S_SQRT) ? -22'(r_sum[0]) : 22'(r_sum[1]);
    assign c_x = (r_state == S_SQRT) ? 22'($signed({1'b0, r_sq_res[20:0]}))
                                     : 22'(r_sum[2]);

    // gyro step and blend, shared over the three axes
    logic signed [42:0] r_prod;
    logic signed [26:0] r_d [3];
    logic signed [42:0] gy_num;
    logic signed [26:0] gy_d;
    logic signed [50:0] r_num;
    logic signed [34:0] bl_q;
    logic signed [31:0] bl_sat;
    logic signed [33:0] yv;
    logic signed [33:0] yw;
    assign gy_num = r_prod + 43'(WINDOW_LENGTH * 32768);
    assign gy_d = 27'(gy_num >>> (16 + $clog2(WINDOW_LENGTH)));
    assign bl_q = 35'((r_num + 51'sd32768) >>> 16);
    assign bl_sat = (bl_q > 35'sd2147483647) ? 32'h7fffffff :
                    (bl_q < -35'sd2147483648) ? 32'h80000000 : 32'(bl_q);
    assign yv = 34'(r_head) + 34'(r_d[2]);
    always_comb begin
        yw = yv;
        if (yv > 34'(HALF_TURN)) yw = yv - 34'(2 * HALF_TURN);
        else if (yv <= -34'(HALF_TURN)) yw = yv + 34'(2 * HALF_TURN);
    end

    // the output register is free when empty or being taken this cycle
    assign out_free = !r_ovalid || out_ch.ready;

    assign in_ch.ready = (r_state == S_IDLE) && !r_clr;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.pitch_q16 = r_opitch;
    assign out_ch.roll_q16 = r_oroll;
    assign out_ch.yaw_deg = r_oyaw;
    assign out_ch.angles_ok = r_ook;

    always_comb begin
        n_state = r_state;
        c_start = 1'b0;
        case (r_state)
            S_IDLE:   if (in_ch.valid && in_ch.ready) n_state = in_ch.read_failed ? S_OUT : S_SUMRD;
            S_SUMRD:  n_state = S_SUMWR;
            S_SUMWR:  n_state = (r_axis == 3'(AXES - 1)) ? S_SQRT : S_SUMRD;
            S_SQRT:   if (r_sq_bit == '0) begin
                n_state = S_CORD_P;
                c_start = 1'b1;
            end
            S_CORD_P: if (c_done) begin
                n_state = S_CORD_R;
                c_start = 1'b1;
            end
            S_CORD_R: if (c_done) n_state = S_GYRO;
            S_GYRO:   if (r_ph == 2'd3) n_state = S_BLEND;
            S_BLEND:  if (r_ph == 2'd3) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blend <= BLEND_RESET;
            r_gain <= GAIN_RESET;
            r_slot <= '0;
            r_clr <= 1'b1;
            r_clr_addr <= '0;
            r_pitch <= '0;
            r_roll <= '0;
            r_head <= '0;
            r_ovalid <= 1'b0;
            r_axis <= '0;
            r_ph <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_ch.valid) begin
                if (cfg_ch.index == 32'(CFG_BLEND)) r_blend <= cfg_ch.data[15:0];
                else if (cfg_ch.index == 32'(CFG_GAIN)) r_gain <= cfg_ch.data[23:0];
            end
            // clear pass over history and sums
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + HAW'(1);
                if (r_clr_addr == HAW'(HDEPTH - 1)) r_clr <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_axis <= '0;
                    r_ph <= '0;
                    if (in_ch.valid && in_ch.ready) begin
                        r_smp[0] <= in_ch.accel_x;
                        r_smp[1] <= in_ch.accel_y;
                        r_smp[2] <= in_ch.accel_z;
                        r_smp[3] <= in_ch.rate_x;
                        r_smp[4] <= in_ch.rate_y;
                        r_smp[5] <= in_ch.rate_z;
                        r_fail <= in_ch.read_failed;
                    end
                end
                S_SUMWR: begin
                    // read data valid now; write back updated sum and sample
                    r_sum[r_axis] <= new_sum;
                    r_axis <= r_axis + 3'd1;
                    if (r_axis == 3'(AXES - 1)) begin
                        r_slot <= (r_slot == SLW'(WINDOW_LENGTH - 1)) ? '0 : r_slot + SLW'(1);
                        r_sq_n <= 44'(38'(r_sum[1]) * 38'(r_sum[1])
                                      + 38'(r_sum[2]) * 38'(r_sum[2]));
                        r_sq_res <= '0;
                        r_sq_bit <= 44'h1 << 42;
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit != '0) begin
                        if (r_sq_n >= sq_t) begin
                            r_sq_n <= r_sq_n - sq_t;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_CORD_P: if (c_done) r_acc_p <= c_angle;
                S_CORD_R: if (c_done) r_acc_r <= c_angle;
                S_GYRO: begin
                    // multiply then shift-with-rounding; each axis is rounded while the next is multiplied
                    r_ph <= r_ph + 2'd1;
                    case (r_ph)
                        2'd0: r_prod <= 43'(r_sum[3]) * $signed({1'b0, r_gain});
                        2'd1: begin
                            r_d[0] <= gy_d;
                            r_prod <= 43'(r_sum[4]) * $signed({1'b0, r_gain});
                        end
                        2'd2: begin
                            r_d[1] <= gy_d;
                            r_prod <= 43'(r_sum[5]) * $signed({1'b0, r_gain});
                        end
                        default: r_d[2] <= gy_d;
                    endcase
                end
                S_BLEND: begin
                    r_ph <= r_ph + 2'd1;
                    case (r_ph)
                        2'd0: r_num <= $signed({1'b0, r_blend}) * (51'(r_pitch) + 51'(r_d[0]))
                                + (51'sd65536 - 51'(r_blend)) * 51'(r_acc_p);
                        2'd1: begin
                            r_pitch <= bl_sat;
                            r_num <= $signed({1'b0, r_blend}) * (51'(r_roll) + 51'(r_d[1]))
                                + (51'sd65536 - 51'(r_blend)) * 51'(r_acc_r);
                        end
                        2'd2: begin
                            r_roll <= bl_sat;
                            r_head <= 32'(yw);
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    // hold until the output register frees
                    if (out_free) begin
                        r_opitch <= r_pitch;
                        r_oroll <= r_roll;
                        r_oyaw <= 25'(r_head);
                        r_ook <= !r_fail;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
